// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_ADDI = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_EQ   = 3'd5,
        OP_GT   = 3'd6,
        OP_LT   = 3'd7
    } t_op;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE     = 4'd0,
        CMD_LOAD     = 4'd1,  // capture request operands
        CMD_SIMPLE   = 4'd2,  // products for addi, mul, div and compares
        CMD_EUC_INIT = 4'd3,  // x = da, y = db
        CMD_REM_GO   = 4'd4,  // start x rem y
        CMD_EUC_STEP = 4'd5,  // x = y, y = remainder
        CMD_LM_MUL   = 4'd6,  // p = da*db
        CMD_LM_GO    = 4'd7,  // start p / g
        CMD_LM_TAKE  = 4'd8,  // lm = quotient, start lm / da
        CMD_QB_GO    = 4'd11, // qa = quotient, start lm / db
        CMD_ADD_FIN  = 4'd13, // n = qa*an + qb*bn
        CMD_FINISH   = 4'd14  // error check and result register
    } t_cmd;

    typedef struct packed {
        logic in_err;   // zero input denominator
        logic y_zero;   // euclid divisor zero
        logic lm_zero;  // multiple wrapped to zero
        logic div_busy;
        t_op  op;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CHECK, S_SIMPLE, S_EINIT, S_ETEST, S_EWAIT, S_LMUL,
        S_LWAIT, S_QAWAIT, S_QBWAIT, S_ADDF, S_FIN, S_OUT
    } t_state;

endpackage

// ===== rtl/core/rau_div.sv =====
module rau_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q, n_q, r_r, n_r, r_d, r_m;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_qneg, r_rneg, r_dz;
    logic [WIDTH:0]   w_sh, w_diff;
    logic [WIDTH-1:0] w_an, w_dn;

    // magnitudes of the operands
    assign w_an = i_num[WIDTH-1] ? (~i_num + 1'b1) : i_num;
    assign w_dn = i_den[WIDTH-1] ? (~i_den + 1'b1) : i_den;

    // one restoring step a cycle
    assign w_sh   = {r_r, r_q[WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    always_comb begin
        if (!w_diff[WIDTH]) begin
            n_r = w_diff[WIDTH-1:0];
            n_q = {r_q[WIDTH-2:0], 1'b1};
        end else begin
            n_r = w_sh[WIDTH-1:0];
            n_q = {r_q[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= w_an;
            r_r    <= '0;
            r_d    <= w_dn;
            r_qneg <= i_num[WIDTH-1] ^ i_den[WIDTH-1];
            r_rneg <= i_num[WIDTH-1];
            r_dz   <= (i_den == '0);
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign r_m    = r_dz ? '0 : r_q;
    assign o_busy = r_busy;
    assign o_quo  = r_qneg ? (~r_m + 1'b1) : r_m;
    assign o_rem  = r_dz ? '0 : (r_rneg ? (~r_r + 1'b1) : r_r);
endmodule

// ===== rtl/core/rau_dp.sv =====
module rau_dp #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rau_pkg::t_cmd         i_cmd,
    input  rau_pkg::t_op          i_op,
    input  logic [WIDTH-1:0]      i_an,
    input  logic [WIDTH-1:0]      i_ad,
    input  logic [WIDTH-1:0]      i_bn,
    input  logic [WIDTH-1:0]      i_bd,
    output rau_pkg::t_stat        o_stat,
    output logic [WIDTH-1:0]      o_rn,
    output logic [WIDTH-1:0]      o_rd,
    output logic                  o_cmp,
    output logic                  o_err
);
    import rau_pkg::*;

    t_op              r_op;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [WIDTH-1:0] r_x, r_y, r_p, r_lm, r_qa, r_t0, r_t1;
    logic [WIDTH-1:0] r_rn, r_rd;
    logic             r_cmp, r_err;
    logic             w_start, w_busy;
    logic [WIDTH-1:0] w_dn, w_dd, w_quo, w_rem;
    logic [WIDTH-1:0] w_m0a, w_m0b, w_m1a, w_m1b, w_m0, w_m1;

    // two shared multipliers, registered outputs
    assign w_m0 = w_m0a * w_m0b;
    assign w_m1 = w_m1a * w_m1b;
    always_comb begin
        w_m0a = r_an; w_m0b = r_bd;
        w_m1a = r_bn; w_m1b = r_ad;
        case (i_cmd)
            CMD_SIMPLE: begin
                case (r_op)
                    OP_ADDI: begin w_m0a = r_ad; w_m0b = r_bn; end
                    OP_MUL:  begin w_m0a = r_an; w_m0b = r_bn;
                                   w_m1a = r_ad; w_m1b = r_bd; end
                    OP_DIV:  begin w_m0a = r_an; w_m0b = r_bd;
                                   w_m1a = r_ad; w_m1b = r_bn; end
                    default: ;
                endcase
            end
            CMD_LM_MUL:  begin w_m0a = r_ad; w_m0b = r_bd; end
            CMD_ADD_FIN: begin w_m0a = r_qa; w_m0b = r_an;
                               w_m1a = w_quo; w_m1b = r_bn; end
            default: ;
        endcase
    end

    always_comb begin
        w_start = 1'b0;
        w_dn    = r_x;
        w_dd    = r_y;
        case (i_cmd)
            CMD_REM_GO:  w_start = 1'b1;
            CMD_LM_GO:   begin w_start = 1'b1; w_dn = r_p;   w_dd = r_x;  end
            CMD_LM_TAKE: begin w_start = 1'b1; w_dn = w_quo; w_dd = r_ad; end
            CMD_QB_GO:   begin w_start = 1'b1; w_dn = r_lm;  w_dd = r_bd; end
            default: ;
        endcase
    end

    rau_div #(.WIDTH(WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_dn),
        .i_den   (w_dd),
        .o_busy  (w_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_ADD;
        end else if (i_cmd == CMD_LOAD) begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_an <= i_an; r_ad <= i_ad; r_bd <= i_bd;
                r_bn <= (i_op == OP_SUB) ? (~i_bn + 1'b1) : i_bn;
            end
            CMD_SIMPLE:   begin r_t0 <= w_m0; r_t1 <= w_m1; end
            CMD_EUC_INIT: begin r_x <= r_ad; r_y <= r_bd; end
            CMD_EUC_STEP: begin r_x <= r_y;  r_y <= w_rem; end
            CMD_LM_MUL:   r_p  <= w_m0;
            CMD_LM_TAKE:  r_lm <= w_quo;
            CMD_QB_GO:    r_qa <= w_quo;
            CMD_ADD_FIN:  begin r_t0 <= w_m0; r_t1 <= w_m1; end
            default: ;
        endcase
    end

    // result assembly
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_FINISH) begin
            logic [WIDTH-1:0] v_n, v_d;
            logic             v_c, v_e;
            v_n = '0; v_d = {{(WIDTH-1){1'b0}}, 1'b1}; v_c = 1'b0;
            case (r_op)
                OP_ADD, OP_SUB: begin v_n = r_t0 + r_t1; v_d = r_lm; end
                OP_ADDI: begin v_n = r_an + r_t0; v_d = r_ad; end
                OP_MUL, OP_DIV: begin v_n = r_t0; v_d = r_t1; end
                OP_EQ:   v_c = (r_an == r_bn) && (r_ad == r_bd);
                OP_GT:   v_c = $signed(r_t0) > $signed(r_t1);
                default: v_c = $signed(r_t1) > $signed(r_t0);
            endcase
            v_e = o_stat.in_err || (r_op <= OP_DIV && v_d == '0);
            r_err <= v_e;
            r_rn  <= v_e ? '0 : v_n;
            r_rd  <= v_e ? '0 : v_d;
            r_cmp <= v_e ? 1'b0 : v_c;
        end
    end

    assign o_stat.in_err   = (r_ad == '0) || (r_op != OP_ADDI && r_bd == '0);
    assign o_stat.y_zero   = (r_y == '0);
    // quotient of p / g as it is taken
    assign o_stat.lm_zero  = (w_quo == '0);
    assign o_stat.div_busy = w_busy;
    assign o_stat.op       = r_op;
    assign o_rn  = r_rn;
    assign o_rd  = r_rd;
    assign o_cmp = r_cmp;
    assign o_err = r_err;
endmodule

// ===== rtl/core/rau_ctrl.sv =====
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LOAD;
            S_LOAD:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.in_err) n_state = S_FIN;
                else if (i_stat.op == OP_ADD || i_stat.op == OP_SUB) n_state = S_EINIT;
                else n_state = S_SIMPLE;
            end
            S_SIMPLE: n_state = S_FIN;
            S_EINIT:  n_state = S_ETEST;
            S_ETEST:  n_state = i_stat.y_zero ? S_LMUL : S_EWAIT;
            S_EWAIT:  if (!i_stat.div_busy) n_state = S_ETEST;
            S_LMUL:   n_state = S_LWAIT;
            S_LWAIT:  if (!i_stat.div_busy) n_state = S_QAWAIT;
            S_QAWAIT: begin
                if (!i_stat.div_busy) n_state = i_stat.lm_zero ? S_FIN : S_QBWAIT;
            end
            S_QBWAIT: if (!i_stat.div_busy) n_state = S_ADDF;
            S_ADDF:   if (!i_stat.div_busy) n_state = S_FIN;
            S_FIN:    n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = CMD_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_LOAD;
            end
            S_SIMPLE: o_cmd = CMD_SIMPLE;
            S_EINIT:  o_cmd = CMD_EUC_INIT;
            S_ETEST:  o_cmd = i_stat.y_zero ? CMD_NONE : CMD_REM_GO;
            S_EWAIT:  if (!i_stat.div_busy) o_cmd = CMD_EUC_STEP;
            S_LMUL:   o_cmd = CMD_LM_MUL;
            S_LWAIT:  if (!i_stat.div_busy) o_cmd = CMD_LM_GO;
            S_QAWAIT: begin
                // first pass takes the multiple, start lm / da
                if (!i_stat.div_busy) o_cmd = CMD_LM_TAKE;
            end
            S_QBWAIT: if (!i_stat.div_busy) o_cmd = CMD_QB_GO;
            S_ADDF: begin
                if (!i_stat.div_busy) o_cmd = CMD_ADD_FIN;
            end
            S_FIN:    o_cmd = CMD_FINISH;
            S_OUT:    o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== rtl/core/rational_arithmetic_unit_top.sv =====
// rational arithmetic unit: one operation on two unreduced fractions per
// request, 32-bit wrapping arithmetic, truncating division. add and subtract
// find the common multiple with euclid on truncating remainders, each
// remainder taken by a shared restoring divider at one bit a cycle, and
// then need three more divisions. one request is in work at a time; the
// result is held on the master side until taken and a new request is taken
// after. status 1 flags a zero input or result denominator and zeroes the
// outputs.
module rational_arithmetic_unit_top #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up
    input  logic [4*WIDTH-1:0] s_axis_tdata,
    // action
    input  logic [2:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // res_num, res_den from bit 0 up
    output logic [2*WIDTH-1:0] m_axis_tdata,
    // compare_true, status from bit 0 up
    output logic [1:0]         m_axis_tuser
);
    import rau_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    t_cmd             w_cmd_dp;
    logic [WIDTH-1:0] w_rn, w_rd;
    logic             w_cmp, w_err;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // the multiple is taken and lm / da started in the same cycle;
    // the qa take and qb start likewise share one cycle
    always_comb begin
        w_cmd_dp = w_cmd;
    end

    rau_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_dp),
        .i_op    (t_op'(s_axis_tuser)),
        .i_an    (s_axis_tdata[WIDTH-1:0]),
        .i_ad    (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .i_bn    (s_axis_tdata[3*WIDTH-1:2*WIDTH]),
        .i_bd    (s_axis_tdata[4*WIDTH-1:3*WIDTH]),
        .o_stat  (w_stat),
        .o_rn    (w_rn),
        .o_rd    (w_rd),
        .o_cmp   (w_cmp),
        .o_err   (w_err)
    );

    assign m_axis_tdata = {w_rd, w_rn};
    assign m_axis_tuser = {w_err, w_cmp};
endmodule
